// ===== rtl/lgs_pkg.sv =====
// lgs_pkg: shared widths, types, register indexes and stencil constants
// for the line gradient stencil unit. No dependencies.

package lgs_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WIN_DEPTH   = 6;
    localparam int ORDER_W     = 2;
    localparam int ROW_LEN_W   = 13;
    localparam int INV_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int TAP_W       = 2;
    localparam int GRAD_W      = 32;

    // stencil sum: up to 40 * |sample| fits in SAMPLE_W + 6 signed bits
    localparam int SUM_W  = SAMPLE_W + 6;
    localparam int PROD_W = SUM_W + INV_W + 1;
    localparam int MAG_W  = PROD_W - 1;
    localparam int RND_W  = MAG_W + 1;
    localparam int QA_W   = RND_W - 8;
    localparam int X_W    = QA_W - 1;

    // x / 3 as (x * RECIP3) >> RCP_S, exact for x below 2**X_W
    localparam int RCP_S = X_W + 2;
    localparam int RCP_W = RCP_S - 1;
    localparam logic [RCP_W-1:0] RECIP3 = RCP_W'(((64'(1) << RCP_S) / 3) + 1);
    localparam int D_PROD_W = X_W + RCP_W;

    localparam logic [RND_W-1:0] RND_ONE = RND_W'(128);
    localparam logic [RND_W-1:0] RND_TWO = RND_W'(256);
    localparam logic [RND_W-1:0] RND_SIX = RND_W'(768);

    localparam logic [ORDER_W-1:0]   ORDER_THREE = ORDER_W'(3);
    localparam logic [ORDER_W-1:0]   ORDER_RST   = ORDER_W'(2);
    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RST = ROW_LEN_W'(64);
    localparam logic [INV_W-1:0]     INV_SP_RST  = INV_W'(256);
    localparam int                   MIN_ROW     = 4;
    localparam int                   FIRST_POS   = 3;
    localparam int                   SECOND_POS  = 4;
    localparam logic [TAP_W-1:0]     TAP_OLDEST  = TAP_W'(3);
    localparam logic [TAP_W-1:0]     TAP_NEWEST  = TAP_W'(0);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_APPROX_ORDER = 2'd0,
        CFG_ROW_LENGTH   = 2'd1,
        CFG_INV_SPACING  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIV_ONE,
        DIV_TWO,
        DIV_SIX
    } div_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t window_t [WIN_DEPTH];
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam sum_t K2  = sum_t'(2);
    localparam sum_t K3  = sum_t'(3);
    localparam sum_t K6  = sum_t'(6);
    localparam sum_t K9  = sum_t'(9);
    localparam sum_t K11 = sum_t'(11);
    localparam sum_t K18 = sum_t'(18);

    // one result request from the window to the stencil
    typedef struct packed {
        logic              valid;
        logic [TAP_W-1:0]  tap;
        logic              first;
        logic              second;
        logic              last;
    } issue_t;

    typedef struct packed {
        logic  valid;
        sum_t  sum;
        div_t  div;
        logic  last;
    } term_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient;
        logic                     last;
    } result_t;

endpackage

// ===== rtl/lgs_window.sv =====
// lgs_window: input transfer, six-sample window, cell position and the
// per-sample result sequencing. Depends on lgs_pkg.

module lgs_window
    import lgs_pkg::*;
#(
    parameter int MAX_ROW = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_sample,
    input  logic [ROW_LEN_W-1:0] row_length,
    input  logic                 adv,
    output window_t              window,
    output issue_t               issue
);

    localparam int NW = ($clog2(MAX_ROW + 1) > ROW_LEN_W) ? $clog2(MAX_ROW + 1) : ROW_LEN_W;
    localparam int PW = $clog2(MAX_ROW);

    window_t          win_reg;
    logic [PW-1:0]    pos_reg;
    logic             job_valid_reg;
    logic             job_end_reg;
    logic             job_k3_reg;
    logic             job_k4_reg;
    logic [TAP_W-1:0] tap_reg;

    logic [NW-1:0] rl_ext;
    logic [NW-1:0] len_eff;
    logic [NW-1:0] last_pos;
    logic [NW-1:0] pos_ext;
    logic          at_end;
    logic          fire;
    logic          job_final;
    logic          accept;

    always_comb begin
        rl_ext = NW'(row_length);
        if (rl_ext < NW'(MIN_ROW)) begin
            len_eff = NW'(MIN_ROW);
        end else if (rl_ext > NW'(MAX_ROW)) begin
            len_eff = NW'(MAX_ROW);
        end else begin
            len_eff = rl_ext;
        end
        last_pos = len_eff - NW'(1);
        pos_ext  = NW'(pos_reg);
        // also true when the line was shortened below the current position
        at_end   = pos_ext >= last_pos;
    end

    assign job_final = !job_end_reg || (tap_reg == TAP_NEWEST);
    assign fire      = job_valid_reg && adv;
    assign s_ready   = !job_valid_reg || (fire && job_final);
    assign accept    = s_valid && s_ready;

    always_comb begin
        issue.valid  = fire;
        issue.tap    = tap_reg;
        issue.first  = job_k3_reg && (tap_reg == TAP_OLDEST);
        issue.second = (job_k4_reg && (tap_reg == TAP_OLDEST)) ||
                       (job_k3_reg && (tap_reg == TAP_W'(2)));
        issue.last   = job_end_reg && (tap_reg == TAP_NEWEST);
    end

    assign window = win_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg[0] <= sample_t'(s_sample);
            for (int i = 1; i < WIN_DEPTH; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            job_valid_reg <= 1'b0;
            job_end_reg   <= 1'b0;
            job_k3_reg    <= 1'b0;
            job_k4_reg    <= 1'b0;
            tap_reg       <= TAP_OLDEST;
        end else begin
            if (accept) begin
                pos_reg       <= at_end ? '0 : pos_reg + PW'(1);
                // the first three samples of a line only fill the window
                job_valid_reg <= pos_ext >= NW'(FIRST_POS);
                job_end_reg   <= at_end;
                job_k3_reg    <= pos_ext == NW'(FIRST_POS);
                job_k4_reg    <= pos_ext == NW'(SECOND_POS);
                tap_reg       <= TAP_OLDEST;
            end else if (fire) begin
                if (job_final) begin
                    job_valid_reg <= 1'b0;
                end else begin
                    tap_reg <= tap_reg - TAP_W'(1);
                end
            end
        end
    end

    a_tap_only_on_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg && !job_end_reg |-> tap_reg == TAP_OLDEST)
        else $error("tap moved on a sample that is not the end of a line");

    a_end_restarts_line: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && at_end |=> pos_reg == '0 && job_valid_reg && job_end_reg)
        else $error("end of line did not restart position and start the flush");

    a_flush_steps_down: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !job_final && !accept |=>
            job_valid_reg && tap_reg == TAP_W'($past(tap_reg) - TAP_W'(1)))
        else $error("flush sequence skipped or repeated a cell");

endmodule

// ===== rtl/lgs_stencil.sv =====
// lgs_stencil: picks the stencil taps for one cell and forms the exact
// stencil sum and divisor code, registered. Depends on lgs_pkg.

module lgs_stencil
    import lgs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic [ORDER_W-1:0] approx_order,
    input  window_t            window,
    input  issue_t             issue,
    output term_t              term
);

    term_t term_reg;
    term_t term_next;

    // s0 is the cell itself, pN the N-th later cell, mN the N-th earlier cell
    sum_t s0, p1, p2, p3, m1, m2, m3;
    logic order3;

    always_comb begin
        s0 = '0; p1 = '0; p2 = '0; p3 = '0;
        m1 = '0; m2 = '0; m3 = '0;
        unique case (issue.tap)
            2'd0: begin
                s0 = sum_t'(window[0]);
                m1 = sum_t'(window[1]);
                m2 = sum_t'(window[2]);
                m3 = sum_t'(window[3]);
            end
            2'd1: begin
                s0 = sum_t'(window[1]);
                p1 = sum_t'(window[0]);
                m1 = sum_t'(window[2]);
                m2 = sum_t'(window[3]);
                m3 = sum_t'(window[4]);
            end
            2'd2: begin
                s0 = sum_t'(window[2]);
                p1 = sum_t'(window[1]);
                p2 = sum_t'(window[0]);
                m1 = sum_t'(window[3]);
                m2 = sum_t'(window[4]);
                m3 = sum_t'(window[5]);
            end
            default: begin
                s0 = sum_t'(window[3]);
                p1 = sum_t'(window[2]);
                p2 = sum_t'(window[1]);
                p3 = sum_t'(window[0]);
                m1 = sum_t'(window[4]);
                m2 = sum_t'(window[5]);
            end
        endcase
    end

    assign order3 = approx_order == ORDER_THREE;

    always_comb begin
        term_next.valid = issue.valid;
        term_next.last  = issue.last;
        if (order3) begin
            term_next.div = DIV_SIX;
            priority if (issue.first) begin
                term_next.sum = K18 * p1 - K11 * s0 - K9 * p2 + K2 * p3;
            end else if (issue.second) begin
                term_next.sum = K6 * p1 - K3 * s0 - p2 - K2 * m1;
            end else if (issue.last) begin
                term_next.sum = K11 * s0 - K18 * m1 + K9 * m2 - K2 * m3;
            end else begin
                term_next.sum = K3 * s0 + K2 * p1 - K6 * m1 + m2;
            end
        end else begin
            priority if (issue.first) begin
                term_next.div = DIV_ONE;
                term_next.sum = p1 - s0;
            end else if (issue.last) begin
                term_next.div = DIV_ONE;
                term_next.sum = s0 - m1;
            end else begin
                term_next.div = DIV_TWO;
                term_next.sum = p1 - m1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg.valid <= 1'b0;
        end else if (adv) begin
            term_reg.valid <= term_next.valid;
        end
        if (adv) begin
            term_reg.sum  <= term_next.sum;
            term_reg.div  <= term_next.div;
            term_reg.last <= term_next.last;
        end
    end

    assign term = term_reg;

endmodule

// ===== rtl/lgs_scale.sv =====
// lgs_scale: multiplies the stencil sum by the reciprocal spacing, then
// divides by 256, 512 or 1536 with round half away from zero.
// Depends on lgs_pkg.

module lgs_scale
    import lgs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [INV_W-1:0] inv_spacing,
    input  term_t            term,
    output logic             res_valid,
    output result_t          res
);

    // product stage
    logic                     b_valid_reg;
    logic signed [PROD_W-1:0] b_prod_reg;
    div_t                     b_div_reg;
    logic                     b_last_reg;

    // rounding stage
    logic                     c_valid_reg;
    logic [QA_W-1:0]          c_qa_reg;
    logic                     c_six_reg;
    logic                     c_neg_reg;
    logic                     c_last_reg;

    // divide-by-three stage
    logic                     d_valid_reg;
    logic [QA_W-1:0]          d_q_reg;
    logic                     d_neg_reg;
    logic                     d_last_reg;

    logic signed [INV_W:0]    inv_s;
    logic signed [PROD_W-1:0] b_prod_next;
    logic [MAG_W-1:0]         mag;
    logic [RND_W-1:0]         rsum;
    logic [QA_W-1:0]          c_qa_next;
    logic [D_PROD_W-1:0]      third;
    logic [QA_W-1:0]          d_q_next;
    logic [GRAD_W-1:0]        q_ext;

    assign inv_s       = $signed({1'b0, inv_spacing});
    assign b_prod_next = PROD_W'(term.sum) * PROD_W'(inv_s);

    always_comb begin
        mag = b_prod_reg[PROD_W-1] ? MAG_W'(-b_prod_reg) : MAG_W'(b_prod_reg);
        unique case (b_div_reg)
            DIV_ONE: rsum = RND_W'(mag) + RND_ONE;
            DIV_TWO: rsum = RND_W'(mag) + RND_TWO;
            DIV_SIX: rsum = RND_W'(mag) + RND_SIX;
            default: rsum = RND_W'(mag) + RND_TWO;
        endcase
        c_qa_next = (b_div_reg == DIV_ONE) ? QA_W'(rsum >> 8) : QA_W'(rsum >> 9);
    end

    assign third    = D_PROD_W'(c_qa_reg[X_W-1:0]) * D_PROD_W'(RECIP3);
    assign d_q_next = c_six_reg ? QA_W'(third >> RCP_S) : c_qa_reg;

    // the magnitude stays below 2**31, so the signed range is never exceeded
    assign q_ext        = GRAD_W'(d_q_reg);
    assign res.gradient = d_neg_reg ? -$signed(q_ext) : $signed(q_ext);
    assign res.last     = d_last_reg;
    assign res_valid    = d_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= term.valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_prod_reg <= b_prod_next;
            b_div_reg  <= term.div;
            b_last_reg <= term.last;
            c_qa_reg   <= c_qa_next;
            c_six_reg  <= b_div_reg == DIV_SIX;
            c_neg_reg  <= b_prod_reg[PROD_W-1];
            c_last_reg <= b_last_reg;
            d_q_reg    <= d_q_next;
            d_neg_reg  <= c_neg_reg;
            d_last_reg <= c_last_reg;
        end
    end

endmodule

// ===== rtl/lgs_skid.sv =====
// lgs_skid: two-entry output buffer; its ready is a register so the result
// port does not reach back into the pipeline. Depends on lgs_pkg.

module lgs_skid
    import lgs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  result_t           in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [GRAD_W-1:0] m_gradient,
    output logic              m_last
);

    result_t main_reg;
    result_t spare_reg;
    logic    main_valid_reg;
    logic    spare_valid_reg;
    logic    push;
    logic    pop;

    assign in_ready = !spare_valid_reg;
    assign push     = in_valid && !spare_valid_reg;
    assign pop      = main_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            if (spare_valid_reg) begin
                if (pop) begin
                    spare_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (!main_valid_reg || pop) begin
                    main_valid_reg <= 1'b1;
                end else begin
                    spare_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (spare_valid_reg) begin
            if (pop) begin
                main_reg <= spare_reg;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg <= in_data;
            end else begin
                spare_reg <= in_data;
            end
        end
    end

    assign m_valid    = main_valid_reg;
    assign m_gradient = main_reg.gradient;
    assign m_last     = main_reg.last;

    a_spare_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> main_valid_reg)
        else $error("spare entry held while the output entry is empty");

    a_stall_fills_spare: assert property (@(posedge aclk) disable iff (!aresetn)
        push && main_valid_reg && !m_ready |=> spare_valid_reg)
        else $error("transfer into a stalled buffer was dropped");

    a_spare_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg && m_ready |=> main_valid_reg && !spare_valid_reg)
        else $error("spare entry not moved to the output on a transfer");

endmodule

// ===== rtl/line_gradient_stencil_unit.sv =====
// line_gradient_stencil_unit: top level, configuration registers and the
// window -> stencil -> scale -> output buffer chain. Depends on lgs_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   input   | s_valid / s_ready  | s_sample (16b signed)
//   result  | m_valid / m_ready  | m_gradient (32b signed), m_last
//   config  | cfg_wr_en          | cfg_index (2b), cfg_wdata (16b)
//
// One sample per cycle while not stalled; a sample that closes a line holds
// the input while its four results are issued one per cycle, again while not
// stalled, through the single scale multiplier. Reset is synchronous on
// aresetn low and restores the register defaults. A stall on m_ready first
// fills the two-entry output buffer, then freezes the pipeline and drops
// s_ready.

module line_gradient_stencil_unit
    import lgs_pkg::*;
#(
    parameter int MAX_ROW = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_W-1:0]    s_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [GRAD_W-1:0]      m_gradient,
    output logic                   m_last,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [ORDER_W-1:0]   approx_order_reg;
    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [INV_W-1:0]     inv_spacing_reg;

    logic    adv;
    window_t window;
    issue_t  issue;
    term_t   term;
    logic    res_valid;
    result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            approx_order_reg <= ORDER_RST;
            row_length_reg   <= ROW_LEN_RST;
            inv_spacing_reg  <= INV_SP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_APPROX_ORDER: approx_order_reg <= cfg_wdata[ORDER_W-1:0];
                CFG_ROW_LENGTH:   row_length_reg   <= cfg_wdata[ROW_LEN_W-1:0];
                CFG_INV_SPACING:  inv_spacing_reg  <= cfg_wdata[INV_W-1:0];
                default: ;
            endcase
        end
    end

    lgs_window #(
        .MAX_ROW (MAX_ROW)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .row_length (row_length_reg),
        .adv        (adv),
        .window     (window),
        .issue      (issue)
    );

    lgs_stencil u_stencil (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .approx_order (approx_order_reg),
        .window       (window),
        .issue        (issue),
        .term         (term)
    );

    lgs_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .inv_spacing (inv_spacing_reg),
        .term        (term),
        .res_valid   (res_valid),
        .res         (res)
    );

    lgs_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (res_valid),
        .in_ready   (adv),
        .in_data    (res),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_gradient (m_gradient),
        .m_last     (m_last)
    );

endmodule

// ===== sim/tb_line_gradient_stencil_unit.sv =====
// tb_line_gradient_stencil_unit: self-checking testbench for the line gradient stencil unit,
// with a cycle-free gradient predictor, random idling on both channels and a watchdog.
// Depends on lgs_pkg and line_gradient_stencil_unit.

module tb_line_gradient_stencil_unit;
    import lgs_pkg::*;

    localparam int     ROW_MAX        = 4096;
    localparam int     RESET_CYCLES   = 5;
    localparam int     SETTLE_CYCLES  = 16;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     LONG_HOLD      = 250;
    localparam int     RANDOM_ITEMS   = 300;
    localparam longint GRAD_HI        = 64'sd2147483647;
    localparam longint GRAD_LO        = -64'sd2147483648;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_W-1:0]    s_sample;
    logic                   m_valid;
    logic                   m_ready;
    logic [GRAD_W-1:0]      m_gradient;
    logic                   m_last;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    line_gradient_stencil_unit #(
        .MAX_ROW(ROW_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_gradient(m_gradient),
        .m_last    (m_last),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state and register shadow
    logic [ORDER_W-1:0]   cur_order   = ORDER_RST;
    logic [ROW_LEN_W-1:0] cur_row_len = ROW_LEN_RST;
    logic [INV_W-1:0]     cur_inv     = INV_SP_RST;
    sample_t              line_win [WIN_DEPTH];
    int unsigned          cell_pos    = 0;
    result_t              expected_grads [$];

    int  mismatch_count = 0;
    int  stall_cycles   = 0;
    int  rx_hold_req    = 0;
    bit  tx_gaps_on     = 1'b1;
    bit  rx_gaps_on     = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned row_cells();
        int unsigned n;
        n = cur_row_len;
        if (n < MIN_ROW) n = MIN_ROW;
        if (n > ROW_MAX) n = ROW_MAX;
        return n;
    endfunction

    // value of absolute cell idx while cell newest is the latest sample
    function automatic longint cell_value(int unsigned newest, longint idx);
        longint off;
        off = longint'(newest) - idx;
        if (off < 0 || off >= WIN_DEPTH) return 0;
        return longint'(line_win[off]);
    endfunction

    function automatic logic signed [GRAD_W-1:0] scale_grad(longint acc, longint div);
        longint den, p, mag, q;
        den = 256 * div;
        p   = acc * longint'(cur_inv);
        mag = (p < 0) ? -p : p;
        q   = (mag + den / 2) / den;
        if (p < 0) q = -q;
        if (q > GRAD_HI) q = GRAD_HI;
        if (q < GRAD_LO) q = GRAD_LO;
        return q[GRAD_W-1:0];
    endfunction

    function automatic logic signed [GRAD_W-1:0] cell_grad(int unsigned k, longint c,
                                                           bit is_last);
        longint s0, acc;
        s0 = cell_value(k, c);
        if (cur_order == ORDER_THREE) begin
            if (c == 0)
                acc = -11 * s0 + 18 * cell_value(k, c + 1) - 9 * cell_value(k, c + 2)
                      + 2 * cell_value(k, c + 3);
            else if (c == 1)
                acc = -3 * s0 + 6 * cell_value(k, c + 1) - cell_value(k, c + 2)
                      - 2 * cell_value(k, c - 1);
            else if (is_last)
                acc = 11 * s0 - 18 * cell_value(k, c - 1) + 9 * cell_value(k, c - 2)
                      - 2 * cell_value(k, c - 3);
            else
                acc = 3 * s0 + 2 * cell_value(k, c + 1) - 6 * cell_value(k, c - 1)
                      + cell_value(k, c - 2);
            return scale_grad(acc, 6);
        end
        // any other order code behaves as second order
        if (c == 0) return scale_grad(cell_value(k, c + 1) - s0, 1);
        if (is_last) return scale_grad(s0 - cell_value(k, c - 1), 1);
        return scale_grad(cell_value(k, c + 1) - cell_value(k, c - 1), 2);
    endfunction

    function automatic void predict_gradients(sample_t v);
        int unsigned n, k;
        bit          at_end;
        longint      c;
        result_t     r;
        n      = row_cells();
        k      = cell_pos;
        at_end = (k >= n - 1);
        for (int i = WIN_DEPTH - 1; i > 0; i--) line_win[i] = line_win[i-1];
        line_win[0] = v;
        // results lag by three cells; the closing sample flushes the rest
        for (int d = 3; d >= 0; d--) begin
            c = longint'(k) - d;
            if (c < 0) continue;
            if (d < 3 && !at_end) break;
            r.last     = at_end && (d == 0);
            r.gradient = cell_grad(k, c, r.last);
            expected_grads.push_back(r);
        end
        cell_pos = at_end ? 0 : k + 1;
    endfunction

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return sample_t'(16'sh7fff);
        if (r == 1) return sample_t'(16'sh8000);
        if (r == 2) return sample_t'($urandom_range(0, 15)) - sample_t'(8);
        return sample_t'($urandom);
    endfunction

    task automatic send_sample(input sample_t v, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_gradients(v);
    endtask

    // stop offering, wait for every pending result, then let the pipeline settle
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_grads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // which: bit 0 order, bit 1 row length, bit 2 inverse spacing
    task automatic configure(input logic [2:0] which, input logic [CFG_DATA_W-1:0] order_word,
                             input logic [CFG_DATA_W-1:0] len_word,
                             input logic [CFG_DATA_W-1:0] inv_word);
        for (int i = 0; i < 3; i++) begin
            if (which[i]) begin
                @(negedge aclk);
                cfg_wr_en <= 1'b1;
                case (i)
                    0: begin
                        cfg_index <= CFG_APPROX_ORDER;
                        cfg_wdata <= order_word;
                    end
                    1: begin
                        cfg_index <= CFG_ROW_LENGTH;
                        cfg_wdata <= len_word;
                    end
                    default: begin
                        cfg_index <= CFG_INV_SPACING;
                        cfg_wdata <= inv_word;
                    end
                endcase
                @(posedge aclk);
                case (i)
                    0:       cur_order   = order_word[ORDER_W-1:0];
                    1:       cur_row_len = len_word[ROW_LEN_W-1:0];
                    default: cur_inv     = inv_word[INV_W-1:0];
                endcase
            end
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(sample_t'(16'sh7fff), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh8000), pick_gap(tx_gaps_on));
        send_sample(sample_t'(0), pick_gap(tx_gaps_on));
        send_sample(sample_t'(-1), pick_gap(tx_gaps_on));
        send_sample(sample_t'(1), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh7fff), pick_gap(tx_gaps_on));
    endtask

    task automatic test_shrink_mid_line();
        // line is six cells in; a length of four closes it on the next sample
        wait_drain();
        configure(3'b010, '0, 16'd4, '0);
        send_sample(rand_sample(), pick_gap(tx_gaps_on));
        wait_drain();
        configure(3'b010, '0, 16'h1fff, '0);
        repeat (5) send_sample(rand_sample(), pick_gap(tx_gaps_on));
        // a length below the minimum clamps to four cells
        wait_drain();
        configure(3'b010, '0, 16'd0, '0);
        send_sample(rand_sample(), pick_gap(tx_gaps_on));
    endtask

    task automatic test_order2_edges();
        wait_drain();
        configure(3'b111, {14'h3fff, 2'd2}, {3'b111, 13'd4}, 16'hffff);
        send_sample(sample_t'(16'sh7fff), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh8000), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh7fff), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh8000), pick_gap(tx_gaps_on));
    endtask

    task automatic test_order3_edges();
        // five cells reach the first, second, interior and last stencils
        wait_drain();
        configure(3'b011, {14'h0, ORDER_THREE}, 16'd5, '0);
        send_sample(sample_t'(16'sh8000), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh7fff), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh8000), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh7fff), pick_gap(tx_gaps_on));
        send_sample(sample_t'(16'sh8000), pick_gap(tx_gaps_on));
    endtask

    task automatic test_order_alias_zero_spacing();
        wait_drain();
        configure(3'b111, 16'd0, 16'd3, 16'd0);
        repeat (4) send_sample(rand_sample(), pick_gap(tx_gaps_on));
    endtask

    task automatic test_backpressure();
        wait_drain();
        configure(3'b111, {14'h0, ORDER_THREE}, 16'd12, 16'($urandom));
        rx_hold_req = LONG_HOLD;
        repeat (36) send_sample(rand_sample(), 0);
    endtask

    task automatic test_random_lines();
        int          sent, cnt, roll;
        int unsigned n;
        logic [2:0]  which;
        logic [CFG_DATA_W-1:0] order_word, len_word, inv_word;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drain();
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            which      = 3'($urandom_range(1, 7));
            order_word = {14'($urandom), ($urandom_range(0, 3) == 0)
                          ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3))};
            roll = $urandom_range(0, 99);
            if (roll < 80)      len_word = 16'($urandom_range(4, 16));
            else if (roll < 90) len_word = 16'($urandom_range(0, 3));
            else if (roll < 95) len_word = ($urandom_range(0, 1) != 0) ? 16'd4096 : 16'h1fff;
            else                len_word = 16'($urandom_range(17, 8191));
            len_word[15:13] = 3'($urandom);
            roll = $urandom_range(0, 9);
            if (roll == 0)      inv_word = 16'd0;
            else if (roll == 1) inv_word = 16'hffff;
            else if (roll < 5)  inv_word = 16'($urandom_range(192, 320));
            else                inv_word = 16'($urandom);
            configure(which, order_word, len_word, inv_word);
            n = row_cells();
            if ($urandom_range(0, 99) < 70 && n <= 32) begin
                // finish the open line, then up to two whole lines
                cnt = (cell_pos >= n - 1) ? 1 : int'(n - cell_pos);
                cnt += $urandom_range(0, 2) * n;
            end else begin
                cnt = $urandom_range(1, 20);
            end
            repeat (cnt) send_sample(rand_sample(), pick_gap(tx_gaps_on));
            sent += cnt;
        end
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = pick_gap(rx_gaps_on);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_grads.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result at %0t: gradient %0d last %0b",
                             $time, $signed(m_gradient), m_last);
                mismatch_count++;
            end else begin
                want = expected_grads.pop_front();
                if (m_gradient !== want.gradient || m_last !== want.last) begin
                    if (mismatch_count < 10)
                        $display("mismatch at %0t: gradient exp %0d got %0d, last exp %0b got %0b",
                                 $time, want.gradient, $signed(m_gradient), want.last, m_last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < WIN_DEPTH; i++) line_win[i] = '0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_sample  = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_APPROX_ORDER;
        cfg_wdata = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_shrink_mid_line();
        test_order2_edges();
        test_order3_edges();
        test_order_alias_zero_spacing();
        test_backpressure();
        test_random_lines();
        wait_drain();

        if (mismatch_count == 0 && expected_grads.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lgs_pkg.sv
rtl/lgs_window.sv
rtl/lgs_stencil.sv
rtl/lgs_scale.sv
rtl/lgs_skid.sv
rtl/line_gradient_stencil_unit.sv
sim/tb_line_gradient_stencil_unit.sv
